// ----- hdl/cms_pkg.sv -----
// ---------------------------------------------------------------------------
// cms_pkg
// Shared types and constants of the charlieplex matrix scanner.
// ---------------------------------------------------------------------------
package cms_pkg;

    // matrix geometry
    localparam int PIN_COUNT = 20;
    localparam int ROW_COUNT = 20;
    localparam int COL_COUNT = 19;

    localparam int ROW_IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_IDX_W = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;
    localparam int PIN_IDX_W = COL_IDX_W + 1;

    // field widths
    localparam int POS_W   = 5;
    localparam int DRIVE_W = 20;
    localparam int DWELL_W = 16;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_DWELL_TICKS = 2'd0;
    localparam logic [DWELL_W-1:0]    DWELL_RESET      = 16'd80;

    // transaction kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // slot waiting to be decoded into a result
    typedef struct packed {
        logic                 valid;
        logic                 frame_end;
        logic [ROW_IDX_W-1:0] row;
        logic [COL_IDX_W-1:0] col;
    } scan_slot_t;

endpackage

// ----- hdl/cms_in_if.sv -----
// ---------------------------------------------------------------------------
// cms_in_if
// Input channel: pixel writes and time ticks.
// ---------------------------------------------------------------------------
interface cms_in_if import cms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [POS_W-1:0] pixel_row;
    logic [POS_W-1:0] pixel_col;
    logic             pixel_on;

    modport source (output valid, func, pixel_row, pixel_col, pixel_on, input ready);
    modport sink   (input valid, func, pixel_row, pixel_col, pixel_on, output ready);
endinterface

// ----- hdl/cms_out_if.sv -----
// ---------------------------------------------------------------------------
// cms_out_if
// Result channel: pin drive of the slot now shown.
// ---------------------------------------------------------------------------
interface cms_out_if import cms_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DRIVE_W-1:0] drive_enable;
    logic [DRIVE_W-1:0] drive_high;
    logic [POS_W-1:0]   scan_row_out;
    logic [POS_W-1:0]   scan_col_out;
    logic               frame_end;

    modport source (output valid, drive_enable, drive_high, scan_row_out, scan_col_out,
                    frame_end, input ready);
    modport sink   (input valid, drive_enable, drive_high, scan_row_out, scan_col_out,
                    frame_end, output ready);
endinterface

// ----- hdl/cms_frame_store.sv -----
// ---------------------------------------------------------------------------
// cms_frame_store
// One-bit frame store with a pixel write port and a single read port.
// ---------------------------------------------------------------------------
module cms_frame_store import cms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [POS_W-1:0]     wr_row,
    input  logic [POS_W-1:0]     wr_col,
    input  logic                 wr_on,
    input  logic [ROW_IDX_W-1:0] rd_row,
    input  logic [COL_IDX_W-1:0] rd_col,
    output logic                 rd_lit
);

    logic [COL_COUNT-1:0] frame_reg [ROW_COUNT];
    logic                 wr_hit;

    // writes outside the matrix are dropped
    assign wr_hit = wr_en && (int'(wr_row) < ROW_COUNT) && (int'(wr_col) < COL_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                frame_reg[r] <= '0;
            end
        end
        else if (wr_hit)
        begin
            frame_reg[wr_row[ROW_IDX_W-1:0]][wr_col[COL_IDX_W-1:0]] <= wr_on;
        end
    end

    assign rd_lit = frame_reg[rd_row][rd_col];

endmodule

// ----- hdl/cms_scan_ctrl.sv -----
// ---------------------------------------------------------------------------
// cms_scan_ctrl
// Dwell counter and row-major slot position, plus the pending slot flag.
// ---------------------------------------------------------------------------
module cms_scan_ctrl import cms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic               take,
    input  logic [DWELL_W-1:0] dwell_ticks,
    output scan_slot_t         slot
);

    logic [DWELL_W-1:0]   dwell_count_reg, dwell_count_next;
    logic [ROW_IDX_W-1:0] row_reg, row_next;
    logic [COL_IDX_W-1:0] col_reg, col_next;
    logic                 pend_reg, pend_next;
    logic                 fend_reg, fend_next;
    logic [DWELL_W-1:0]   count_inc;
    logic                 advance;
    logic                 col_last;
    logic                 row_last;

    assign count_inc = dwell_count_reg + DWELL_W'(1);
    // a dwell of zero advances on every tick
    assign advance   = (count_inc >= dwell_ticks) || (count_inc == '0);
    assign col_last  = (col_reg == COL_IDX_W'(COL_COUNT - 1));
    assign row_last  = (row_reg == ROW_IDX_W'(ROW_COUNT - 1));

    always_comb
    begin
        dwell_count_next = dwell_count_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        fend_next        = fend_reg;
        pend_next        = take ? 1'b0 : pend_reg;
        if (tick)
        begin
            pend_next        = 1'b1;
            fend_next        = 1'b0;
            dwell_count_next = count_inc;
            if (advance)
            begin
                dwell_count_next = '0;
                if (col_last)
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        row_next  = '0;
                        fend_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_IDX_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_count_reg <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            pend_reg        <= 1'b0;
            fend_reg        <= 1'b0;
        end
        else
        begin
            dwell_count_reg <= dwell_count_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            pend_reg        <= pend_next;
            fend_reg        <= fend_next;
        end
    end

    assign slot.valid     = pend_reg;
    assign slot.frame_end = fend_reg;
    assign slot.row       = row_reg;
    assign slot.col       = col_reg;

endmodule

// ----- hdl/cms_drive_out.sv -----
// ---------------------------------------------------------------------------
// cms_drive_out
// Decodes the pending slot into pin drives and holds the result register.
// ---------------------------------------------------------------------------
module cms_drive_out import cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scan_slot_t slot,
    input  logic       lit,
    output logic       take,
    cms_out_if.source  out_ch
);

    logic                 valid_reg, valid_next;
    logic [DRIVE_W-1:0]   enable_reg, high_reg;
    logic [POS_W-1:0]     row_out_reg, col_out_reg;
    logic                 fend_reg;
    logic [PIN_IDX_W-1:0] cathode;
    logic                 pins_ok;
    logic [DRIVE_W-1:0]   anode_bit, cathode_bit;

    assign take = slot.valid && (!valid_reg || out_ch.ready);

    // cathode skips the anode pin
    assign cathode = (PIN_IDX_W'(slot.col) < PIN_IDX_W'(slot.row))
                   ? PIN_IDX_W'(slot.col)
                   : PIN_IDX_W'(slot.col) + PIN_IDX_W'(1);
    assign pins_ok     = (int'(slot.row) < PIN_COUNT) && (int'(cathode) < PIN_COUNT);
    assign anode_bit   = DRIVE_W'(1) << slot.row;
    assign cathode_bit = DRIVE_W'(1) << cathode;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            enable_reg  <= (lit && pins_ok) ? (anode_bit | cathode_bit) : '0;
            high_reg    <= (lit && pins_ok) ? anode_bit : '0;
            row_out_reg <= POS_W'(slot.row);
            col_out_reg <= POS_W'(slot.col);
            fend_reg    <= slot.frame_end;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.drive_enable = enable_reg;
    assign out_ch.drive_high   = high_reg;
    assign out_ch.scan_row_out = row_out_reg;
    assign out_ch.scan_col_out = col_out_reg;
    assign out_ch.frame_end    = fend_reg;

endmodule

// ----- hdl/charlieplex_matrix_scanner_core.sv -----
// ---------------------------------------------------------------------------
// charlieplex_matrix_scanner_core
// Charlieplexed LED matrix refresh: frame store, slot scan and pin drive.
// ---------------------------------------------------------------------------
// in_ch carries one transaction per item: func 0 writes one pixel of the
// frame store (out-of-range rows or columns are dropped), func 1 is a time
// tick. Every tick yields exactly one out_ch transaction holding the pin
// drive of the slot shown after the tick; pixel writes yield nothing.
// The scan position and dwell counter are registered when a tick is
// accepted, and the slot is then decoded against the frame store into the
// result register once that register is empty or out_ch.ready is high.
// Throughput is one item per cycle while in_ch.ready is high.
// in_ch.ready falls only when a slot is waiting to be decoded and the result
// register is full and stalled by out_ch.ready; no state moves meanwhile.
// Reset clears the frame store, scan position and dwell count, and loads
// dwell_ticks with 80. dwell_ticks is written through the APB port at
// byte address 0 and should only be changed while the block is idle.
// ---------------------------------------------------------------------------
module charlieplex_matrix_scanner_core import cms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    cms_in_if.sink                in_ch,
    cms_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [DWELL_W-1:0] dwell_ticks_reg, dwell_ticks_next;
    scan_slot_t         slot;
    logic               take;
    logic               in_acc;
    logic               lit;

    // configuration register
    always_comb
    begin
        dwell_ticks_next = dwell_ticks_reg;
        if (psel && penable && pwrite && (paddr == ADDR_DWELL_TICKS))
        begin
            dwell_ticks_next = pwdata[DWELL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_ticks_reg <= DWELL_RESET;
        end
        else
        begin
            dwell_ticks_reg <= dwell_ticks_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DWELL_TICKS) ? APB_DATA_W'(dwell_ticks_reg) : '0;

    assign in_ch.ready = !slot.valid || take;
    assign in_acc      = in_ch.valid && in_ch.ready;

    cms_frame_store u_frame
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (in_acc && (in_ch.func == FUNC_PIXEL)),
        .wr_row (in_ch.pixel_row),
        .wr_col (in_ch.pixel_col),
        .wr_on  (in_ch.pixel_on),
        .rd_row (slot.row),
        .rd_col (slot.col),
        .rd_lit (lit)
    );

    cms_scan_ctrl u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (in_acc && (in_ch.func == FUNC_TICK)),
        .take        (take),
        .dwell_ticks (dwell_ticks_reg),
        .slot        (slot)
    );

    cms_drive_out u_drive
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .slot   (slot),
        .lit    (lit),
        .take   (take),
        .out_ch (out_ch)
    );

`ifndef SYNTH
    // high is only ever asserted on a driven pin
    a_high_in_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((out_ch.drive_high & ~out_ch.drive_enable) == '0))
        else $error("drive_high set on an undriven pin");

    // a lit slot drives exactly an anode and a cathode
    a_two_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (($countones(out_ch.drive_enable) == 0) ||
                          (($countones(out_ch.drive_enable) == 2) &&
                           ($countones(out_ch.drive_high) == 1))))
        else $error("pin drive is not a single anode/cathode pair");

    // frame end coincides with the return to the first slot
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.frame_end) |->
            ((out_ch.scan_row_out == '0) && (out_ch.scan_col_out == '0)))
        else $error("frame_end without wrap to first slot");

    // a stalled result with a slot waiting blocks further input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (slot.valid && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
        else $error("input accepted while pending slot is stalled");
`endif

endmodule
